// ----- hdl/vss_pkg.sv -----
// Package for the vector similarity scorer: types, constants, register indexes.
package vss_pkg;

    localparam int ACC_W  = 48;
    localparam int NORM_W = 24;
    localparam int IDX_W  = 16;
    localparam int ROWS   = 65536;
    localparam int CFG_IDX_W = 2;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_DOT = 2'd0,
        MODE_NRM = 2'd1,
        MODE_L2  = 2'd2,
        MODE_COS = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE  = 2'd0,
        CFG_QNORM = 2'd1,
        CFG_USE   = 2'd2,
        CFG_NONE  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] a_elem;
        logic signed [15:0] b_elem;
        logic [NORM_W-1:0]  supplied_norm;
        logic               last;
        logic               last_row;
    } in_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] score;
        logic [IDX_W-1:0]        row_index;
        logic                    saturated;
    } out_item_t;

    // One finished row handed from front to back end
    typedef struct packed {
        logic signed [ACC_W-1:0] main_sum;
        logic [ACC_W-1:0]        sq_sum;
        logic [NORM_W-1:0]       supplied_norm;
        logic [NORM_W-1:0]       query_norm;
        logic                    cosine;
        logic                    use_supplied;
        logic                    sat;
        logic [IDX_W-1:0]        row_index;
    } row_job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQRT,
        BK_MUL,
        BK_DIV,
        BK_DONE
    } bk_state_t;

    // Saturating signed add of a 48-bit sum and a nonnegative/signed term
    function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                               input logic signed [ACC_W-1:0] term);
        logic signed [ACC_W:0] s;
        begin
            s = {acc[ACC_W-1], acc} + {term[ACC_W-1], term};
            if (s > $signed({1'b0, ACC_MAX}))
                sat_add = {1'b1, ACC_MAX};
            else if (s < $signed({1'b1, ACC_MIN}))
                sat_add = {1'b1, ACC_MIN};
            else
                sat_add = {1'b0, s[ACC_W-1:0]};
        end
    endfunction

endpackage

// ----- hdl/vss_front.sv -----
// Front end: per-element multiply and saturating row accumulation.
module vss_front
    import vss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  in_item_t            in_item,
    input  mode_t               mode,
    input  logic [NORM_W-1:0]   query_norm,
    input  logic                use_supplied,
    input  logic                q_full,
    output logic                stall,
    output logic                job_valid,
    output row_job_t            job
);

    // Stage 1: products, registered
    logic                       s1_valid_reg;
    in_item_t                   s1_item_reg;
    mode_t                      s1_mode_reg;
    logic                       s1_sq_en_reg;
    logic signed [33:0]         s1_main_reg;
    logic signed [31:0]         s1_sq_reg;

    logic signed [16:0]         diff;
    logic signed [16:0]         opa;
    logic signed [16:0]         opb;
    logic signed [33:0]         prod_main;
    logic signed [31:0]         prod_sq;

    logic signed [ACC_W-1:0]    main_sum_reg;
    logic signed [ACC_W-1:0]    sq_sum_reg;
    logic                       clamp_reg;
    logic [IDX_W-1:0]           row_cnt_reg;
    logic [ACC_W:0]             main_add;
    logic [ACC_W:0]             sq_add;
    logic                       row_end;

    // Stall the whole front end while a finished row cannot be queued
    assign row_end = s1_valid_reg && s1_item_reg.last;
    assign stall   = row_end && q_full;

    always_comb
    begin
        diff = $signed({in_item.a_elem[15], in_item.a_elem})
             - $signed({in_item.b_elem[15], in_item.b_elem});
        opa = $signed({in_item.a_elem[15], in_item.a_elem});
        opb = $signed({in_item.b_elem[15], in_item.b_elem});
        case (mode)
            MODE_NRM: opb = opa;
            MODE_L2:
            begin
                opa = diff;
                opb = diff;
            end
            default: ;
        endcase
        prod_main = opa * opb;
        prod_sq   = in_item.b_elem * in_item.b_elem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall && in_valid)
        begin
            s1_item_reg  <= in_item;
            s1_mode_reg  <= mode;
            s1_sq_en_reg <= (mode == MODE_COS) && !use_supplied;
            s1_main_reg  <= prod_main;
            s1_sq_reg    <= prod_sq;
        end
    end

    // Stage 2: saturating accumulation
    assign main_add = sat_add(main_sum_reg, ACC_W'(s1_main_reg));
    assign sq_add   = s1_sq_en_reg ? sat_add(sq_sum_reg, ACC_W'(s1_sq_reg))
                                   : {1'b0, sq_sum_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_sum_reg <= '0;
            sq_sum_reg   <= '0;
            clamp_reg    <= 1'b0;
            row_cnt_reg  <= '0;
        end
        else if (s1_valid_reg && !stall)
        begin
            if (s1_item_reg.last)
            begin
                main_sum_reg <= '0;
                sq_sum_reg   <= '0;
                clamp_reg    <= 1'b0;
                if (s1_item_reg.last_row || ({1'b0, row_cnt_reg} + 17'd1) >= 17'(ROWS))
                    row_cnt_reg <= '0;
                else
                    row_cnt_reg <= row_cnt_reg + 1'b1;
            end
            else
            begin
                main_sum_reg <= main_add[ACC_W-1:0];
                sq_sum_reg   <= sq_add[ACC_W-1:0];
                clamp_reg    <= clamp_reg | main_add[ACC_W] | sq_add[ACC_W];
            end
        end
    end

    // Row job goes to the queue on the last element (registers sampled now)
    assign job_valid           = row_end && !q_full;
    assign job.main_sum        = main_add[ACC_W-1:0];
    assign job.sq_sum          = sq_add[ACC_W-1:0];
    assign job.supplied_norm   = s1_item_reg.supplied_norm;
    assign job.query_norm      = query_norm;
    assign job.cosine          = (s1_mode_reg == MODE_COS);
    assign job.use_supplied    = use_supplied;
    assign job.sat             = clamp_reg | main_add[ACC_W] | sq_add[ACC_W];
    assign job.row_index       = row_cnt_reg;

endmodule

// ----- hdl/vss_queue.sv -----
// Small FIFO of row jobs between the front and back ends.
module vss_queue
    import vss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  row_job_t  wr_data,
    output logic      full,
    input  logic      rd_en,
    output logic      empty,
    output row_job_t  rd_data
);

    row_job_t          mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full    = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- hdl/vss_back.sv -----
// Back end: row norm square root, norm product and cosine divide, one row at a time.
module vss_back
    import vss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_avail,
    input  row_job_t  job,
    output logic      job_take,
    output logic      res_valid,
    output out_item_t res,
    input  logic      res_take
);

    bk_state_t          state_reg, state_next;
    row_job_t           job_reg;
    logic [5:0]         cnt_reg;

    // Square root: two radicand bits per cycle
    logic [ACC_W-1:0]   rad_reg;
    logic [25:0]        rem_reg;
    logic [23:0]        root_reg;
    logic [25:0]        trial;
    logic [25:0]        rem_sh;

    // Divider: restoring, one quotient bit per cycle
    logic [47:0]        den_reg;
    logic [62:0]        num_reg;
    logic [48:0]        drem_reg;
    logic [62:0]        quo_reg;
    logic [48:0]        drem_sh;
    logic [ACC_W-1:0]   mag;
    logic               neg_reg;
    logic [NORM_W-1:0]  rn;
    logic               zero_norm;
    logic signed [ACC_W-1:0] cos_score;
    logic               cos_sat;

    out_item_t          res_reg;
    logic               res_valid_reg;

    assign rn = job_reg.use_supplied ? job_reg.supplied_norm : root_reg;
    assign mag = job.main_sum[ACC_W-1] ? (ACC_W'(0) - job.main_sum) : job.main_sum;

    assign rem_sh  = {rem_reg[23:0], rad_reg[ACC_W-1 -: 2]};
    assign trial   = rem_sh - {root_reg, 2'b01};
    assign drem_sh = {drem_reg[47:0], num_reg[62]};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (job_avail)
                    state_next = (job.cosine && !job.use_supplied) ? BK_SQRT : BK_MUL;
            BK_SQRT:
                if (cnt_reg == 6'd23)
                    state_next = BK_MUL;
            BK_MUL:
                state_next = (!job_reg.cosine || zero_norm) ? BK_DONE : BK_DIV;
            BK_DIV:
                if (cnt_reg == 6'd62)
                    state_next = BK_DONE;
            BK_DONE:
                if (!res_valid_reg || res_take)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        job_take = (state_reg == BK_IDLE) && job_avail;
    end

    assign zero_norm = (job_reg.query_norm == '0) || (rn == '0);

    // Cosine clamp
    always_comb
    begin
        cos_sat = 1'b0;
        if (neg_reg)
        begin
            if (quo_reg > 63'd32768)
            begin
                cos_score = -ACC_W'(32768);
                cos_sat   = 1'b1;
            end
            else
                cos_score = ACC_W'(0) - ACC_W'(quo_reg);
        end
        else
        begin
            if (quo_reg > 63'd32767)
            begin
                cos_score = ACC_W'(32767);
                cos_sat   = 1'b1;
            end
            else
                cos_score = ACC_W'(quo_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_DONE && (!res_valid_reg || res_take))
                res_valid_reg <= 1'b1;
            else if (res_take)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                job_reg  <= job;
                rad_reg  <= job.sq_sum;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                neg_reg  <= job.main_sum[ACC_W-1];
                num_reg  <= {mag, 15'd0};
                drem_reg <= '0;
                quo_reg  <= '0;
            end
            BK_SQRT:
            begin
                rad_reg <= {rad_reg[ACC_W-3:0], 2'b00};
                cnt_reg <= cnt_reg + 1'b1;
                if (!trial[25])
                begin
                    rem_reg  <= trial;
                    root_reg <= {root_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[22:0], 1'b0};
                end
            end
            BK_MUL:
            begin
                den_reg <= job_reg.query_norm * rn;
                cnt_reg <= '0;
            end
            BK_DIV:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                num_reg <= {num_reg[61:0], 1'b0};
                if (drem_sh >= {1'b0, den_reg})
                begin
                    drem_reg <= drem_sh - {1'b0, den_reg};
                    quo_reg  <= {quo_reg[61:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem_sh;
                    quo_reg  <= {quo_reg[61:0], 1'b0};
                end
            end
            BK_DONE:
            begin
                if (!res_valid_reg || res_take)
                begin
                    res_reg.row_index <= job_reg.row_index;
                    if (!job_reg.cosine)
                    begin
                        res_reg.score     <= job_reg.main_sum;
                        res_reg.saturated <= job_reg.sat;
                    end
                    else if (zero_norm)
                    begin
                        res_reg.score     <= '0;
                        res_reg.saturated <= job_reg.sat;
                    end
                    else
                    begin
                        res_reg.score     <= cos_score;
                        res_reg.saturated <= job_reg.sat | cos_sat;
                    end
                end
            end
            default: ;
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- hdl/vector_similarity_scorer.sv -----
// Top level of the vector similarity scorer.
//
// Usage: element pairs enter through push/full, one per cycle while full is
// low. The front end multiplies and accumulates each row in two stages; the
// item marked last hands a row job (sums, norms, row index) to a four-entry
// queue. The back end takes one job at a time: modes 0 to 2 pass the row
// sum through as the score; cosine mode uses one multiply and a 63-step
// restoring divider, plus a square root when the row norm is computed.
// Results wait in an output register read through empty/pop.
// Throughput: one element per cycle; rows shorter than the back-end time
// fill the queue and then full stalls input until the back end drains.
// Configuration writes through cfg_valid/cfg_ready are always taken and must
// only occur while the block is idle. Reset clears all sums, the row counter
// and the queue; registers return to mode 0, query_norm 4096, supplied norm.
// A stalled receiver holds the result, then the queue, then the input.
module vector_similarity_scorer
    import vss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  in_item_t          in_data,
    output logic              empty,
    input  logic              pop,
    output out_item_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]       cfg_data
);

    mode_t              mode_reg;
    logic [NORM_W-1:0]  qnorm_reg;
    logic               use_reg;
    logic               stall;
    logic               job_valid;
    row_job_t           job;
    logic               q_full;
    logic               q_empty;
    row_job_t           q_data;
    logic               job_take;
    logic               res_valid;

    assign cfg_ready = 1'b1;
    assign full      = stall;
    assign empty     = !res_valid;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_DOT;
            qnorm_reg <= NORM_W'(4096);
            use_reg   <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MODE:  mode_reg  <= mode_t'(cfg_data[1:0]);
                CFG_QNORM: qnorm_reg <= cfg_data[NORM_W-1:0];
                CFG_USE:   use_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    vss_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (push),
        .in_item      (in_data),
        .mode         (mode_reg),
        .query_norm   (qnorm_reg),
        .use_supplied (use_reg),
        .q_full       (q_full),
        .stall        (stall),
        .job_valid    (job_valid),
        .job          (job)
    );

    vss_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_valid),
        .wr_data (job),
        .full    (q_full),
        .rd_en   (job_take),
        .empty   (q_empty),
        .rd_data (q_data)
    );

    vss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (!q_empty),
        .job       (q_data),
        .job_take  (job_take),
        .res_valid (res_valid),
        .res       (out_data),
        .res_take  (pop)
    );

endmodule
